// ----- rtl/smpq_pkg.sv -----
// ---------------------------------------------------------------------------
// smpq_pkg
// Shared types and constants of the sorted max priority queue.
// ---------------------------------------------------------------------------
package smpq_pkg;

   localparam int CAPACITY = 16;
   localparam int COUNT_W  = $clog2(CAPACITY + 1);
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int RSP_COUNT_W = 5;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   // broadcast to every cell in the chain
   typedef struct packed {
      logic                      insert;
      logic                      remove;
      logic signed [VALUE_W-1:0] value;
   } cell_ctl_type;

endpackage

// ----- rtl/smpq_req_if.sv -----
// ---------------------------------------------------------------------------
// smpq_req_if
// Request channel: valid/ready handshake with a command and a value.
// ---------------------------------------------------------------------------
interface smpq_req_if;
   logic                              valid;
   logic                              ready;
   logic                              cmd;
   logic signed [smpq_pkg::VALUE_W-1:0] value;

   modport source (output valid, output cmd, output value, input ready);
   modport sink   (input valid, input cmd, input value, output ready);
endinterface

// ----- rtl/smpq_rsp_if.sv -----
// ---------------------------------------------------------------------------
// smpq_rsp_if
// Response channel: valid/ready handshake with the removed value and status.
// ---------------------------------------------------------------------------
interface smpq_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [smpq_pkg::VALUE_W-1:0]   max_value;
   logic [smpq_pkg::STATUS_W-1:0]         status;
   logic [smpq_pkg::RSP_COUNT_W-1:0]      count;
   logic                                  is_empty;

   modport source (output valid, output max_value, output status, output count,
                   output is_empty, input ready);
   modport sink   (input valid, input max_value, input status, input count,
                   input is_empty, output ready);
endinterface

// ----- rtl/sorted_max_priority_queue.sv -----
// ---------------------------------------------------------------------------
// sorted_max_priority_queue
// Max priority queue kept sorted in a chain of compare-and-shift cells.
// ---------------------------------------------------------------------------
//  channel   dir  handshake     payload
//  req_chan  in   valid/ready   cmd, value
//  rsp_chan  out  valid/ready   max_value, status, count, is_empty
//
//  every request is applied to all cells together: each cell does one signed compare against
//  the broadcast value and shifts or loads in the same edge
//  one request per cycle is sustained while rsp_chan.ready stays high
//  the response register frees itself when taken, so a new request enters
//  in the same cycle; a stalled response holds req_chan.ready low
//  reset clears the fill count and response valid; cells are not cleared
// ---------------------------------------------------------------------------
module sorted_max_priority_queue (
   input  logic            clock,
   input  logic            reset,
   smpq_req_if.sink        req_chan,
   smpq_rsp_if.source      rsp_chan
);

   localparam int N = smpq_pkg::CAPACITY;

   logic [smpq_pkg::COUNT_W-1:0]        count_ff, count_in;
   logic                                rsp_valid_ff;
   logic signed [smpq_pkg::VALUE_W-1:0] max_value_ff, max_value_in;
   smpq_pkg::status_type                status_ff, status_in;

   logic                                accept;
   logic                                is_full;
   logic                                no_entries;
   smpq_pkg::cell_ctl_type              ctl;

   logic                                cell_take  [N];
   logic signed [smpq_pkg::VALUE_W-1:0] cell_value [N];

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign is_full        = count_ff == smpq_pkg::COUNT_W'(N);
   assign no_entries     = count_ff == '0;

   always_comb begin
      ctl.insert = accept && (req_chan.cmd == smpq_pkg::CMD_INSERT) && !is_full;
      ctl.remove = accept && (req_chan.cmd == smpq_pkg::CMD_REMOVE) && !no_entries;
      ctl.value  = req_chan.value;
   end

   for (genvar i = 0; i < N; i++) begin : g_cell
      logic                                prev_take;
      logic signed [smpq_pkg::VALUE_W-1:0] prev_value;
      logic signed [smpq_pkg::VALUE_W-1:0] next_value;

      if (i == 0) begin : g_head
         assign prev_take  = 1'b0;
         assign prev_value = req_chan.value;
      end else begin : g_body
         assign prev_take  = cell_take[i-1];
         assign prev_value = cell_value[i-1];
      end

      if (i == N - 1) begin : g_tail
         assign next_value = cell_value[i];
      end else begin : g_inner
         assign next_value = cell_value[i+1];
      end

      smpq_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .occupied   (smpq_pkg::COUNT_W'(i) < count_ff),
         .prev_take  (prev_take),
         .prev_value (prev_value),
         .next_value (next_value),
         .take       (cell_take[i]),
         .value      (cell_value[i])
      );
   end

   always_comb begin
      count_in     = count_ff;
      max_value_in = '0;
      status_in    = smpq_pkg::STATUS_OK;
      if (req_chan.cmd == smpq_pkg::CMD_INSERT) begin
         if (is_full) begin
            status_in = smpq_pkg::STATUS_FULL;
         end else begin
            count_in = count_ff + 1'b1;
         end
      end else begin
         if (no_entries) begin
            status_in = smpq_pkg::STATUS_EMPTY;
         end else begin
            count_in     = count_ff - 1'b1;
            max_value_in = cell_value[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         max_value_ff <= max_value_in;
         status_ff    <= status_in;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.max_value = max_value_ff;
   assign rsp_chan.status    = status_ff;
   assign rsp_chan.count     = smpq_pkg::RSP_COUNT_W'(count_ff);
   assign rsp_chan.is_empty  = no_entries;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= smpq_pkg::COUNT_W'(N))
      else $error("fill count above capacity");

   a_head_sorted: assert property (@(posedge clock) disable iff (reset)
      count_ff >= smpq_pkg::COUNT_W'(2) |-> cell_value[0] >= cell_value[1])
      else $error("head of chain out of order");

   a_remove_count: assert property (@(posedge clock) disable iff (reset)
      ctl.remove |=> count_ff == $past(count_ff) - 1'b1)
      else $error("remove did not decrement count");

   a_insert_head: assert property (@(posedge clock) disable iff (reset)
      ctl.insert && no_entries |=> cell_value[0] == $past(req_chan.value))
      else $error("insert into empty queue lost value");
`endif

endmodule

// ----- rtl/smpq_cell.sv -----
// ---------------------------------------------------------------------------
// smpq_cell
// One slot of the sorted chain: compares, then keeps, shifts or loads.
// ---------------------------------------------------------------------------
module smpq_cell (
   input  logic                                 clock,
   input  smpq_pkg::cell_ctl_type               ctl,
   input  logic                                 occupied,
   input  logic                                 prev_take,
   input  logic signed [smpq_pkg::VALUE_W-1:0]  prev_value,
   input  logic signed [smpq_pkg::VALUE_W-1:0]  next_value,
   output logic                                 take,
   output logic signed [smpq_pkg::VALUE_W-1:0]  value
);

   logic signed [smpq_pkg::VALUE_W-1:0] value_ff;
   logic signed [smpq_pkg::VALUE_W-1:0] value_in;

   // new value belongs at or before this slot (ties stay in front)
   assign take = !occupied || (ctl.value > value_ff);

   always_comb begin
      value_in = value_ff;
      if (ctl.insert && take) begin
         value_in = prev_take ? prev_value : ctl.value;
      end else if (ctl.remove) begin
         value_in = next_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

// ----- tb/sorted_max_priority_queue_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sorted_max_priority_queue_tb
// Drives insert and remove requests into the priority queue and checks each
// reply against a shadow sorted list kept in the bench. A short table walks
// the edges (empty, full, extreme and equal values), then random traffic
// swings the fill level between empty and full with random stalls on both
// channels, apart from one stretch with no stalls on either side.
// ---------------------------------------------------------------------------
module sorted_max_priority_queue_tb;

   localparam int NUM_RANDOM  = 600;
   localparam int STALL_LIMIT = 2000;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic signed [smpq_pkg::VALUE_W-1:0] max_value;
      logic [smpq_pkg::STATUS_W-1:0]       status;
      logic [smpq_pkg::RSP_COUNT_W-1:0]    count;
      logic                                is_empty;
   } queue_reply_type;

   typedef struct {
      logic                                cmd;
      logic signed [smpq_pkg::VALUE_W-1:0] value;
      bit                                  typed;
      queue_reply_type                     reply;
   } table_row_type;

   logic clock;
   logic reset;

   smpq_req_if req_chan ();
   smpq_rsp_if rsp_chan ();

   sorted_max_priority_queue u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // shadow copy of the sorted list
   logic signed [smpq_pkg::VALUE_W-1:0] shadow_entries [smpq_pkg::CAPACITY];
   int                                  shadow_fill;

   queue_reply_type queued_replies [$];
   table_row_type   edge_rows [$];

   int mismatches;
   int quiet_cycles;
   int req_idle_pct;
   int rsp_idle_pct;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic queue_reply_type sorted_queue_step(
      input logic cmd, input logic signed [smpq_pkg::VALUE_W-1:0] value);
      queue_reply_type r;
      int              pos;
      r = '0;
      r.status = smpq_pkg::STATUS_OK;
      if (cmd == smpq_pkg::CMD_INSERT) begin
         if (shadow_fill >= smpq_pkg::CAPACITY) begin
            r.status = smpq_pkg::STATUS_FULL;
         end else begin
            pos = 0;
            // newcomer goes behind every equal value
            while (pos < shadow_fill && !(value > shadow_entries[pos])) pos++;
            for (int i = shadow_fill; i > pos; i--) shadow_entries[i] = shadow_entries[i-1];
            shadow_entries[pos] = value;
            shadow_fill++;
         end
      end else begin
         if (shadow_fill == 0) begin
            r.status = smpq_pkg::STATUS_EMPTY;
         end else begin
            r.max_value = shadow_entries[0];
            for (int i = 1; i < shadow_fill; i++) shadow_entries[i-1] = shadow_entries[i];
            shadow_fill--;
         end
      end
      r.count    = shadow_fill[smpq_pkg::RSP_COUNT_W-1:0];
      r.is_empty = (shadow_fill == 0);
      return r;
   endfunction

   function automatic void add_row(input logic cmd,
                                   input logic signed [smpq_pkg::VALUE_W-1:0] value,
                                   input bit typed,
                                   input logic signed [smpq_pkg::VALUE_W-1:0] max_value,
                                   input smpq_pkg::status_type status, input int count,
                                   input logic is_empty);
      table_row_type row;
      row.cmd             = cmd;
      row.value           = value;
      row.typed           = typed;
      row.reply.max_value = max_value;
      row.reply.status    = status;
      row.reply.count     = count[smpq_pkg::RSP_COUNT_W-1:0];
      row.reply.is_empty  = is_empty;
      edge_rows.push_back(row);
   endfunction

   function automatic logic signed [smpq_pkg::VALUE_W-1:0] pick_value();
      case ($urandom_range(3))
         0: return $urandom_range(8) - 4;
         1: begin
            case ($urandom_range(3))
               0: return 32'sh7fffffff;
               1: return 32'sh80000000;
               2: return 32'sh0;
               default: return -32'sd1;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   // request task: random idle, hold until accepted, then predict
   task automatic send_request(input logic cmd,
                               input logic signed [smpq_pkg::VALUE_W-1:0] value,
                               input bit typed, input queue_reply_type typed_reply);
      queue_reply_type predicted;
      while (req_idle_pct != 0 && $urandom_range(99) < req_idle_pct) begin
         req_chan.valid <= 1'b0;
         req_chan.cmd   <= 1'($urandom_range(1));
         req_chan.value <= $urandom;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.cmd   <= cmd;
      req_chan.value <= value;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      predicted = sorted_queue_step(cmd, value);
      queued_replies.push_back(typed ? typed_reply : predicted);
      @(negedge clock);
   endtask

   task automatic wait_for_drain();
      req_chan.valid <= 1'b0;
      while (queued_replies.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic note_mismatch(input string field,
                                input logic [smpq_pkg::VALUE_W-1:0] want,
                                input logic [smpq_pkg::VALUE_W-1:0] got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("%0t: %s mismatch, expected %h, got %h", $realtime, field, want, got);
   endtask

   // response side stalls
   always @(negedge clock) begin
      if (rsp_idle_pct == 0) rsp_chan.ready <= 1'b1;
      else rsp_chan.ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   // reply checker
   always @(posedge clock) begin : check_reply
      queue_reply_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (queued_replies.size() == 0) begin
            note_mismatch("unexpected reply", '0, rsp_chan.max_value);
         end else begin
            want = queued_replies.pop_front();
            if (rsp_chan.max_value !== want.max_value)
               note_mismatch("max_value", want.max_value, rsp_chan.max_value);
            if (rsp_chan.status !== want.status)
               note_mismatch("status", smpq_pkg::VALUE_W'(want.status),
                             smpq_pkg::VALUE_W'(rsp_chan.status));
            if (rsp_chan.count !== want.count)
               note_mismatch("count", smpq_pkg::VALUE_W'(want.count),
                             smpq_pkg::VALUE_W'(rsp_chan.count));
            if (rsp_chan.is_empty !== want.is_empty)
               note_mismatch("is_empty", smpq_pkg::VALUE_W'(want.is_empty),
                             smpq_pkg::VALUE_W'(rsp_chan.is_empty));
         end
      end
   end

   // watchdog on cycles with no request or reply moving
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      queue_reply_type none;
      logic            cmd;
      int              insert_pct;
      none           = '0;
      mismatches     = 0;
      quiet_cycles   = 0;
      shadow_fill    = 0;
      req_idle_pct   = 32;
      rsp_idle_pct   = 32;
      reset          = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.cmd   = smpq_pkg::CMD_INSERT;
      req_chan.value = '0;
      rsp_chan.ready = 1'b0;

      // edge table: empty, extremes, equal values, full
      add_row(smpq_pkg::CMD_REMOVE, 32'sh0,        1, 32'sh0, smpq_pkg::STATUS_EMPTY, 0, 1'b1);
      add_row(smpq_pkg::CMD_INSERT, 32'sh7fffffff, 1, 32'sh0, smpq_pkg::STATUS_OK,    1, 1'b0);
      add_row(smpq_pkg::CMD_INSERT, 32'sh80000000, 1, 32'sh0, smpq_pkg::STATUS_OK,    2, 1'b0);
      add_row(smpq_pkg::CMD_INSERT, 32'sh0,        0, 32'sh0, smpq_pkg::STATUS_OK, 0, 1'b0);
      add_row(smpq_pkg::CMD_INSERT, -32'sd1,       0, 32'sh0, smpq_pkg::STATUS_OK, 0, 1'b0);
      add_row(smpq_pkg::CMD_INSERT, 32'sh0,        0, 32'sh0, smpq_pkg::STATUS_OK, 0, 1'b0);
      add_row(smpq_pkg::CMD_INSERT, 32'sh7fffffff, 0, 32'sh0, smpq_pkg::STATUS_OK, 0, 1'b0);
      add_row(smpq_pkg::CMD_INSERT, 32'sd1,        0, 32'sh0, smpq_pkg::STATUS_OK, 0, 1'b0);
      add_row(smpq_pkg::CMD_INSERT, 32'sd1,        0, 32'sh0, smpq_pkg::STATUS_OK, 0, 1'b0);
      add_row(smpq_pkg::CMD_INSERT, -32'sd2,       0, 32'sh0, smpq_pkg::STATUS_OK, 0, 1'b0);
      add_row(smpq_pkg::CMD_INSERT, 32'sd100,      0, 32'sh0, smpq_pkg::STATUS_OK, 0, 1'b0);
      add_row(smpq_pkg::CMD_INSERT, 32'sh40000000, 0, 32'sh0, smpq_pkg::STATUS_OK, 0, 1'b0);
      add_row(smpq_pkg::CMD_INSERT, 32'shc0000000, 0, 32'sh0, smpq_pkg::STATUS_OK, 0, 1'b0);
      add_row(smpq_pkg::CMD_INSERT, 32'sd5,        0, 32'sh0, smpq_pkg::STATUS_OK, 0, 1'b0);
      add_row(smpq_pkg::CMD_INSERT, 32'sh80000000, 0, 32'sh0, smpq_pkg::STATUS_OK, 0, 1'b0);
      add_row(smpq_pkg::CMD_INSERT, 32'sh7ffffffe, 0, 32'sh0, smpq_pkg::STATUS_OK, 0, 1'b0);
      add_row(smpq_pkg::CMD_INSERT, 32'sh80000001, 0, 32'sh0, smpq_pkg::STATUS_OK, 0, 1'b0);
      add_row(smpq_pkg::CMD_INSERT, 32'sh12345678, 1, 32'sh0, smpq_pkg::STATUS_FULL, 16, 1'b0);
      add_row(smpq_pkg::CMD_REMOVE, 32'shffffffff, 1, 32'sh7fffffff, smpq_pkg::STATUS_OK, 15,
              1'b0);
      add_row(smpq_pkg::CMD_REMOVE, 32'sh0,        1, 32'sh7fffffff, smpq_pkg::STATUS_OK, 14,
              1'b0);
      add_row(smpq_pkg::CMD_REMOVE, 32'sh0,        0, 32'sh0, smpq_pkg::STATUS_OK, 0, 1'b0);
      add_row(smpq_pkg::CMD_REMOVE, 32'sh0,        0, 32'sh0, smpq_pkg::STATUS_OK, 0, 1'b0);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (edge_rows[i])
         send_request(edge_rows[i].cmd, edge_rows[i].value, edge_rows[i].typed,
                      edge_rows[i].reply);
      wait_for_drain();

      insert_pct = 50;
      for (int n = 0; n < NUM_RANDOM; n++) begin
         // swing the fill level so both full and empty are hit often
         if (n % 40 == 0) begin
            case ((n / 40) % 5)
               0: insert_pct = 75;
               1: insert_pct = 25;
               2: insert_pct = 90;
               3: insert_pct = 10;
               default: insert_pct = 50;
            endcase
         end
         // back-to-back stretch with no stalls on either side
         req_idle_pct = (n >= 200 && n < 350) ? 0 : 32;
         rsp_idle_pct = req_idle_pct;
         if (n == 420) wait_for_drain();
         cmd = ($urandom_range(99) < insert_pct) ? smpq_pkg::CMD_INSERT : smpq_pkg::CMD_REMOVE;
         send_request(cmd, pick_value(), 0, none);
      end

      wait_for_drain();
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
